FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, switched off while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dsse_pkg.sv
// ----------------------------------------------------------------------------
// dsse_pkg
// types, constants and the month table of the date to epoch seconds converter
// ----------------------------------------------------------------------------
`default_nettype none

package dsse_pkg;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SEC_W    = 6;

   localparam int SECS_W  = 32;
   localparam int DOY_W   = 9;
   localparam int DAYS_W  = 16;
   localparam int TOD_W   = 17;
   localparam int CENT_W  = 6;
   localparam int BASE_W  = 10;

   localparam int REQ_FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SEC_W;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_FIELDS_W = SECS_W + DOY_W + DAYS_W;
   localparam int RSP_DATA_W   = 64;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR         = 12'd2000;
   localparam logic [DAYS_W-1:0]  LEAPS_BEFORE_EPOCH = 16'd484;
   localparam logic [DAYS_W-1:0]  COMMON_YEAR_LEN    = 16'd365;
   localparam logic [DAYS_W-1:0]  DOY_BIAS           = 16'd91;
   localparam logic [DAYS_W-1:0]  MARCH_ADJUST       = 16'd2;
   localparam logic [MONTH_W-1:0] MARCH              = 4'd3;

   // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT, exact for 12-bit n
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          RECIP_PROD_W = YEAR_W + 13;

   localparam logic [TOD_W-1:0]    SECS_PER_HOUR   = 17'd3600;
   localparam logic [TOD_W-1:0]    SECS_PER_MINUTE = 17'd60;
   localparam logic [SECS_W:0]     SECS_PER_DAY    = 33'd86400;

   // first field in the highest bits, year in the lowest bits
   typedef struct packed {
      logic [SEC_W-1:0]    sec;
      logic [MINUTE_W-1:0] minute;
      logic [HOUR_W-1:0]   hour;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } req_fields_type;

   typedef struct packed {
      logic [DAYS_W-1:0] ydn;
      logic [DAYS_W-1:0] cdn;
   } days_type;

   // (month + 2) * 611 / 20
   function automatic logic [BASE_W-1:0] month_base(input logic [MONTH_W-1:0] month);
      logic [BASE_W-1:0] base;
      case (month)
         4'd0:    base = 10'd61;
         4'd1:    base = 10'd91;
         4'd2:    base = 10'd122;
         4'd3:    base = 10'd152;
         4'd4:    base = 10'd183;
         4'd5:    base = 10'd213;
         4'd6:    base = 10'd244;
         4'd7:    base = 10'd274;
         4'd8:    base = 10'd305;
         4'd9:    base = 10'd336;
         4'd10:   base = 10'd366;
         4'd11:   base = 10'd397;
         4'd12:   base = 10'd427;
         4'd13:   base = 10'd458;
         4'd14:   base = 10'd488;
         default: base = 10'd519;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/date_to_seconds_since_epoch_top.sv
// ----------------------------------------------------------------------------
// date_to_seconds_since_epoch_top: calendar date and time to epoch seconds
// one transfer per cycle while rsp_tready does not stall the output
// stages: input register, day count register after the century multiply,
// result register after the days by 86400 multiply; each stalls only when full
// reset clears the stage valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module date_to_seconds_since_epoch_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], sec[37:32]
   input  logic [dsse_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // epoch_seconds[31:0], day_of_year[40:32], epoch_days[56:41]
   output logic [dsse_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic out_ready;
   logic r1_ready;
   logic r0_ready;

   logic                     r0_valid_ff;
   logic                     r0_valid_in;
   dsse_pkg::req_fields_type fields_ff;
   dsse_pkg::req_fields_type fields_in;

   logic                       r1_valid_ff;
   logic                       r1_valid_in;
   dsse_pkg::days_type         days_a;
   dsse_pkg::days_type         days_ff;
   dsse_pkg::days_type         days_in;
   logic [dsse_pkg::TOD_W-1:0] tod_a;
   logic [dsse_pkg::TOD_W-1:0] tod_ff;
   logic [dsse_pkg::TOD_W-1:0] tod_in;

   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [dsse_pkg::SECS_W:0]   day_secs;
   logic [dsse_pkg::SECS_W-1:0] secs_b;
   logic [dsse_pkg::SECS_W-1:0] secs_ff;
   logic [dsse_pkg::SECS_W-1:0] secs_in;
   logic [dsse_pkg::DOY_W-1:0]  doy_ff;
   logic [dsse_pkg::DOY_W-1:0]  doy_in;
   logic [dsse_pkg::DAYS_W-1:0] cdn_ff;
   logic [dsse_pkg::DAYS_W-1:0] cdn_in;

   // a stage takes new data when it is empty or its content moves on
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign r1_ready   = !r1_valid_ff || out_ready;
   assign r0_ready   = !r0_valid_ff || r1_ready;
   assign req_tready = r0_ready;

   // input register
   assign r0_valid_in = r0_ready ? req_tvalid : r0_valid_ff;
   assign fields_in   = (r0_ready && req_tvalid) ?
                        dsse_pkg::req_fields_type'(req_tdata[dsse_pkg::REQ_FIELDS_W-1:0]) :
                        fields_ff;

   // day numbers and time of day
   dsse_days u_days (
      .year  (fields_ff.year),
      .month (fields_ff.month),
      .day   (fields_ff.day),
      .days  (days_a)
   );

   assign tod_a = dsse_pkg::TOD_W'(fields_ff.hour) * dsse_pkg::SECS_PER_HOUR +
                  dsse_pkg::TOD_W'(fields_ff.minute) * dsse_pkg::SECS_PER_MINUTE +
                  dsse_pkg::TOD_W'(fields_ff.sec);

   assign r1_valid_in = r1_ready ? r0_valid_ff : r1_valid_ff;
   assign days_in     = (r1_ready && r0_valid_ff) ? days_a : days_ff;
   assign tod_in      = (r1_ready && r0_valid_ff) ? tod_a : tod_ff;

   // seconds
   assign day_secs = (dsse_pkg::SECS_W+1)'(days_ff.cdn) * dsse_pkg::SECS_PER_DAY;
   assign secs_b   = day_secs[dsse_pkg::SECS_W-1:0] + dsse_pkg::SECS_W'(tod_ff);

   assign out_valid_in = out_ready ? r1_valid_ff : out_valid_ff;
   assign secs_in      = (out_ready && r1_valid_ff) ? secs_b : secs_ff;
   assign doy_in       = (out_ready && r1_valid_ff) ? days_ff.ydn[dsse_pkg::DOY_W-1:0] : doy_ff;
   assign cdn_in       = (out_ready && r1_valid_ff) ? days_ff.cdn : cdn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff  <= 1'b0;
         r1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         r0_valid_ff  <= r0_valid_in;
         r1_valid_ff  <= r1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
      days_ff   <= days_in;
      tod_ff    <= tod_in;
      secs_ff   <= secs_in;
      doy_ff    <= doy_in;
      cdn_ff    <= cdn_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(dsse_pkg::RSP_DATA_W - dsse_pkg::RSP_FIELDS_W)'(0),
                        cdn_ff, doy_ff, secs_ff};

   `ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> !r0_valid_ff && !r1_valid_ff && !rsp_tvalid, "pipeline not empty after reset")
   `ASSERT_RST(a_stall_only_full, clock, reset,
      !req_tready |-> r0_valid_ff && r1_valid_ff && rsp_tvalid && !rsp_tready,
      "input stalled with room in the pipeline")
   `ASSERT_RST(a_accept_fills, clock, reset,
      req_tvalid && req_tready |=> r0_valid_ff, "input transfer lost")
   `ASSERT_RST(a_mid_holds, clock, reset,
      r1_valid_ff && !out_ready |=> r1_valid_ff && $stable(days_ff) && $stable(tod_ff),
      "middle stage changed while blocked")

endmodule

`default_nettype wire

FILE: rtl/dsse_days.sv
// ----------------------------------------------------------------------------
// dsse_days
// day of year and day count since 2000-01-01 from year, month and day
// ----------------------------------------------------------------------------
`default_nettype none

module dsse_days (
   input  logic [dsse_pkg::YEAR_W-1:0]  year,
   input  logic [dsse_pkg::MONTH_W-1:0] month,
   input  logic [dsse_pkg::DAY_W-1:0]   day,
   output dsse_pkg::days_type           days
);

   logic [dsse_pkg::YEAR_W-1:0]       prev_year;
   logic [dsse_pkg::RECIP_PROD_W-1:0] prod_year;
   logic [dsse_pkg::RECIP_PROD_W-1:0] prod_prev;
   logic [dsse_pkg::CENT_W-1:0]       cent_year;
   logic [dsse_pkg::CENT_W-1:0]       cent_prev;
   logic                              leap;
   logic [dsse_pkg::DAYS_W-1:0]       ydn_raw;
   logic [dsse_pkg::DAYS_W-1:0]       ydn;
   logic [dsse_pkg::YEAR_W-1:0]       span;
   logic [dsse_pkg::DAYS_W-1:0]       span_days;
   logic [dsse_pkg::DAYS_W-1:0]       leap_days;
   logic [dsse_pkg::DAYS_W-1:0]       year_days;

   assign prev_year = year - 12'd1;

   // two parallel reciprocal multiplies give the century of this and the previous year
   assign prod_year = dsse_pkg::RECIP_PROD_W'(year) *
                      dsse_pkg::RECIP_PROD_W'(dsse_pkg::RECIP_100);
   assign prod_prev = dsse_pkg::RECIP_PROD_W'(prev_year) *
                      dsse_pkg::RECIP_PROD_W'(dsse_pkg::RECIP_100);
   assign cent_year = prod_year[dsse_pkg::RECIP_SHIFT +: dsse_pkg::CENT_W];
   assign cent_prev = prod_prev[dsse_pkg::RECIP_SHIFT +: dsse_pkg::CENT_W];

   // a century boundary lies at year exactly when the two centuries differ
   assign leap = (year == '0) ||
                 ((year[1:0] == 2'b00) && (cent_year == cent_prev)) ||
                 (cent_year[dsse_pkg::CENT_W-1:2] != cent_prev[dsse_pkg::CENT_W-1:2]);

   assign ydn_raw = dsse_pkg::DAYS_W'(dsse_pkg::month_base(month)) +
                    dsse_pkg::DAYS_W'(day) - dsse_pkg::DOY_BIAS;

   always_comb begin
      if (month >= dsse_pkg::MARCH) begin
         ydn = ydn_raw - dsse_pkg::MARCH_ADJUST + dsse_pkg::DAYS_W'(leap);
      end else begin
         ydn = ydn_raw;
      end
   end

   assign span      = year - dsse_pkg::EPOCH_YEAR;
   assign span_days = dsse_pkg::DAYS_W'(span) * dsse_pkg::COMMON_YEAR_LEN;
   assign leap_days = dsse_pkg::DAYS_W'(prev_year[dsse_pkg::YEAR_W-1:2]) -
                      dsse_pkg::DAYS_W'(cent_prev) +
                      dsse_pkg::DAYS_W'(cent_prev[dsse_pkg::CENT_W-1:2]) -
                      dsse_pkg::LEAPS_BEFORE_EPOCH;

   always_comb begin
      if (year > dsse_pkg::EPOCH_YEAR) begin
         year_days = span_days + leap_days;
      end else begin
         year_days = '0;
      end
   end

   assign days.ydn = ydn;
   assign days.cdn = ydn - 16'd1 + year_days;

endmodule

`default_nettype wire
